// File: rtl/core/rdtv_pkg.sv
// rdtv_pkg: shared types and codes of the rfc3339 date-time validator
// used by the parser front end, the word queue and the range-check back end
package rdtv_pkg;

  localparam logic [1:0] FMT_DATE_TIME = 2'd0;
  localparam logic [1:0] FMT_DATE      = 2'd1;
  localparam logic [1:0] FMT_TIME      = 2'd2;
  localparam logic [1:0] FMT_BAD       = 2'd3;

  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_SYNTAX   = 4'd1;
  localparam logic [3:0] ERR_MONTH    = 4'd2;
  localparam logic [3:0] ERR_DAY      = 4'd3;
  localparam logic [3:0] ERR_HOUR     = 4'd4;
  localparam logic [3:0] ERR_MINUTE   = 4'd5;
  localparam logic [3:0] ERR_OFF_HOUR = 4'd6;
  localparam logic [3:0] ERR_OFF_MIN  = 4'd7;
  localparam logic [3:0] ERR_SECOND   = 4'd8;

  // parsed string, one entry per finished run
  typedef struct packed {
    logic [1:0] fmt;
    logic       syn_bad;
    logic [6:0] year_hi;
    logic [6:0] year_lo;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic       off_neg;
    logic [6:0] off_hour;
    logic [6:0] off_min;
  } snap_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// File: rtl/core/rdtv_front.sv
// rdtv_front: byte-wide syntax parser and field accumulators
// depends on rdtv_pkg; pushes one parsed entry per string into rdtv_queue
module rdtv_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic [7:0]          char_byte,
  input  logic                last_char,
  input  rdtv_pkg::q_status_t q_status,
  output logic                push,
  output rdtv_pkg::snap_t     snap
);

  localparam logic [4:0] PH_START     = 5'd0;
  localparam logic [4:0] PH_Y0        = 5'd1;
  localparam logic [4:0] PH_Y1        = 5'd2;
  localparam logic [4:0] PH_Y2        = 5'd3;
  localparam logic [4:0] PH_Y3        = 5'd4;
  localparam logic [4:0] PH_DASH1     = 5'd5;
  localparam logic [4:0] PH_MO0       = 5'd6;
  localparam logic [4:0] PH_MO1       = 5'd7;
  localparam logic [4:0] PH_DASH2     = 5'd8;
  localparam logic [4:0] PH_DA0       = 5'd9;
  localparam logic [4:0] PH_DA1       = 5'd10;
  localparam logic [4:0] PH_DATE_END  = 5'd11;
  localparam logic [4:0] PH_H0        = 5'd12;
  localparam logic [4:0] PH_H1        = 5'd13;
  localparam logic [4:0] PH_COL1      = 5'd14;
  localparam logic [4:0] PH_MI0       = 5'd15;
  localparam logic [4:0] PH_MI1       = 5'd16;
  localparam logic [4:0] PH_COL2      = 5'd17;
  localparam logic [4:0] PH_S0        = 5'd18;
  localparam logic [4:0] PH_S1        = 5'd19;
  localparam logic [4:0] PH_AFTER_SEC = 5'd20;
  localparam logic [4:0] PH_FRAC1     = 5'd21;
  localparam logic [4:0] PH_FRAC      = 5'd22;
  localparam logic [4:0] PH_OH0       = 5'd23;
  localparam logic [4:0] PH_OH1       = 5'd24;
  localparam logic [4:0] PH_OCOL      = 5'd25;
  localparam logic [4:0] PH_OM0       = 5'd26;
  localparam logic [4:0] PH_OM1       = 5'd27;
  localparam logic [4:0] PH_DONE      = 5'd28;

  function automatic logic [6:0] acc2(input logic [6:0] a, input logic [3:0] dg);
    logic [10:0] t;
    t = {4'd0, a} * 11'd10 + {7'd0, dg};
    return t[6:0];
  endfunction

  logic [4:0]      phase;
  logic            syntax_bad;
  rdtv_pkg::snap_t acc;

  logic [4:0]      p;
  logic [4:0]      phase_next;
  logic            bad_next;
  logic [4:0]      want;
  rdtv_pkg::snap_t acc_next;
  logic            start;
  logic            dig;
  logic            zulu;
  logic            sgn;
  logic            accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && last_char;

  always_comb begin
    start = (phase == PH_START);
    dig   = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    zulu  = (char_byte == "Z") || (char_byte == "z");
    sgn   = (char_byte == "+") || (char_byte == "-");
    p     = start ? ((mode == rdtv_pkg::FMT_TIME) ? PH_H0 : PH_Y0) : phase;
    acc_next = acc;
    if (start) acc_next.fmt = mode;
    phase_next = p;
    bad_next   = syntax_bad || (start && (mode == rdtv_pkg::FMT_BAD));
    if (!bad_next) begin
      case (p)
        PH_Y0, PH_Y1: begin
          if (dig) begin
            acc_next.year_hi = acc2(acc.year_hi, char_byte[3:0]);
            phase_next = p + 5'd1;
          end else bad_next = 1'b1;
        end
        PH_Y2, PH_Y3: begin
          if (dig) begin
            acc_next.year_lo = acc2(acc.year_lo, char_byte[3:0]);
            phase_next = p + 5'd1;
          end else bad_next = 1'b1;
        end
        PH_MO0, PH_MO1: begin
          if (dig) begin
            acc_next.month = acc2(acc.month, char_byte[3:0]);
            phase_next = p + 5'd1;
          end else bad_next = 1'b1;
        end
        PH_DA0, PH_DA1: begin
          if (dig) begin
            acc_next.day = acc2(acc.day, char_byte[3:0]);
            phase_next = p + 5'd1;
          end else bad_next = 1'b1;
        end
        PH_H0, PH_H1: begin
          if (dig) begin
            acc_next.hour = acc2(acc.hour, char_byte[3:0]);
            phase_next = p + 5'd1;
          end else bad_next = 1'b1;
        end
        PH_MI0, PH_MI1: begin
          if (dig) begin
            acc_next.minute = acc2(acc.minute, char_byte[3:0]);
            phase_next = p + 5'd1;
          end else bad_next = 1'b1;
        end
        PH_S0, PH_S1: begin
          if (dig) begin
            acc_next.second = acc2(acc.second, char_byte[3:0]);
            phase_next = p + 5'd1;
          end else bad_next = 1'b1;
        end
        PH_OH0, PH_OH1: begin
          if (dig) begin
            acc_next.off_hour = acc2(acc.off_hour, char_byte[3:0]);
            phase_next = p + 5'd1;
          end else bad_next = 1'b1;
        end
        PH_OM0, PH_OM1: begin
          if (dig) begin
            acc_next.off_min = acc2(acc.off_min, char_byte[3:0]);
            phase_next = p + 5'd1;
          end else bad_next = 1'b1;
        end
        PH_DASH1, PH_DASH2: begin
          if (char_byte == "-") phase_next = p + 5'd1;
          else bad_next = 1'b1;
        end
        PH_COL1, PH_COL2, PH_OCOL: begin
          if (char_byte == ":") phase_next = p + 5'd1;
          else bad_next = 1'b1;
        end
        PH_DATE_END: begin
          if ((acc_next.fmt == rdtv_pkg::FMT_DATE_TIME) &&
              ((char_byte == "T") || (char_byte == "t"))) phase_next = PH_H0;
          else bad_next = 1'b1;
        end
        PH_AFTER_SEC, PH_FRAC: begin
          if ((p == PH_AFTER_SEC) && (char_byte == ".")) phase_next = PH_FRAC1;
          else if ((p == PH_FRAC) && dig) phase_next = PH_FRAC;
          else if (zulu) phase_next = PH_DONE;
          else if (sgn) begin
            acc_next.off_neg = (char_byte == "-");
            phase_next = PH_OH0;
          end else bad_next = 1'b1;
        end
        PH_FRAC1: begin
          if (dig) phase_next = PH_FRAC;
          else bad_next = 1'b1;
        end
        default: bad_next = 1'b1;
      endcase
    end
    want = (acc_next.fmt == rdtv_pkg::FMT_DATE) ? PH_DATE_END : PH_DONE;
    snap = acc_next;
    snap.syn_bad = bad_next || (phase_next != want);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      syntax_bad <= 1'b0;
      acc        <= '0;
    end else if (accept) begin
      if (last_char) begin
        phase      <= PH_START;
        syntax_bad <= 1'b0;
        acc        <= '0;
      end else begin
        phase      <= phase_next;
        syntax_bad <= bad_next;
        acc        <= acc_next;
      end
    end
  end

endmodule

// File: rtl/core/rdtv_queue.sv
// rdtv_queue: two-entry word queue between parser and checker
// depends on rdtv_pkg for the entry and status types
module rdtv_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rdtv_pkg::snap_t     wr_data,
  input  logic                pop,
  output rdtv_pkg::snap_t     rd_data,
  output rdtv_pkg::q_status_t status
);

  rdtv_pkg::snap_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign rd_data      = mem[rd_ptr];
  assign status.empty = (count == 2'd0);
  assign status.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/rdtv_back.sv
// rdtv_back: range checks on a parsed entry and the result output register
// depends on rdtv_pkg; pops entries from rdtv_queue
module rdtv_back (
  input  logic                clk,
  input  logic                rst,
  input  rdtv_pkg::snap_t     head,
  input  rdtv_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                valid_res,
  output logic [3:0]          error_code
);

  logic        leap;
  logic [6:0]  dmax;
  logic [3:0]  date_err;
  logic [3:0]  time_err;
  logic [3:0]  err;
  logic [12:0] t_min;
  logic [12:0] o_min;
  logic [14:0] diff;
  logic [6:0]  smax;

  assign pop = !q_status.empty && (!out_valid || !out_stall);

  always_comb begin
    leap = (head.year_lo[1:0] == 2'd0) && ((head.year_lo != 7'd0) ||
           (head.year_hi[1:0] == 2'd0));
    if (head.month == 7'd2) dmax = leap ? 7'd29 : 7'd28;
    else if (head.month <= 7'd7) dmax = head.month[0] ? 7'd31 : 7'd30;
    else dmax = head.month[0] ? 7'd30 : 7'd31;
    if ((head.month < 7'd1) || (head.month > 7'd12)) date_err = rdtv_pkg::ERR_MONTH;
    else if ((head.day < 7'd1) || (head.day > dmax)) date_err = rdtv_pkg::ERR_DAY;
    else date_err = rdtv_pkg::ERR_OK;

    t_min = {6'd0, head.hour} * 13'd60 + {6'd0, head.minute};
    o_min = {6'd0, head.off_hour} * 13'd60 + {6'd0, head.off_min};
    diff  = head.off_neg ? ({2'b00, t_min} + {2'b00, o_min})
                         : ({2'b00, t_min} - {2'b00, o_min});
    // utc 23:59 after wrapping into one day
    smax  = ((diff == 15'd1439) || (diff == 15'h7fff)) ? 7'd60 : 7'd59;

    if (head.hour > 7'd23) time_err = rdtv_pkg::ERR_HOUR;
    else if (head.minute > 7'd59) time_err = rdtv_pkg::ERR_MINUTE;
    else if (head.off_hour > 7'd23) time_err = rdtv_pkg::ERR_OFF_HOUR;
    else if (head.off_min > 7'd59) time_err = rdtv_pkg::ERR_OFF_MIN;
    else if (head.second > smax) time_err = rdtv_pkg::ERR_SECOND;
    else time_err = rdtv_pkg::ERR_OK;

    if (head.syn_bad) err = rdtv_pkg::ERR_SYNTAX;
    else if ((head.fmt != rdtv_pkg::FMT_TIME) && (date_err != rdtv_pkg::ERR_OK))
      err = date_err;
    else if (head.fmt != rdtv_pkg::FMT_DATE) err = time_err;
    else err = rdtv_pkg::ERR_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      valid_res  <= (err == rdtv_pkg::ERR_OK);
      error_code <= err;
    end
  end

endmodule

// File: rtl/core/rfc3339_date_time_validator.sv
// rfc3339_date_time_validator: validates one date, time or date-time string
// per run, one byte per cycle while in_stall is low. The first byte of a
// string takes the format from mode; the byte marked last_char ends the
// string and gives one result word with the first failing check. Bytes are
// accepted in every cycle without in_stall; the parser hands each finished
// string to a two-entry queue, and the checker pops it into the registered
// output once that register is free. in_stall rises only while the queue is
// full, which happens only while a result waits at the output. Depends on
// rdtv_pkg, rdtv_front, rdtv_queue and rdtv_back.
module rfc3339_date_time_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] char_byte,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       valid_res,
  output logic [3:0] error_code
);

  rdtv_pkg::snap_t     wr_snap;
  rdtv_pkg::snap_t     head;
  rdtv_pkg::q_status_t q_status;
  logic                q_push;
  logic                q_pop;

  rdtv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .char_byte (char_byte),
    .last_char (last_char),
    .q_status  (q_status),
    .push      (q_push),
    .snap      (wr_snap)
  );

  rdtv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (wr_snap),
    .pop     (q_pop),
    .rd_data (head),
    .status  (q_status)
  );

  rdtv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .valid_res  (valid_res),
    .error_code (error_code)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_full_means_waiting: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> out_valid)
    else $error("queue full with no result waiting");

  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> out_valid)
    else $error("popped word did not reach the output");

  a_ok_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_res == (error_code == rdtv_pkg::ERR_OK)))
    else $error("valid_res disagrees with error_code");
`endif

endmodule

// File: test/rfc3339_date_time_validator_tb.sv
`timescale 1ns / 100ps
// rfc3339_date_time_validator_tb: feeds date, time and date-time strings one byte per word
// and checks every verdict against a byte-level parser kept in the bench
// depends on rdtv_pkg and the rfc3339_date_time_validator rtl
module rfc3339_date_time_validator_tb;

  localparam logic [4:0] P_START     = 5'd0;
  localparam logic [4:0] P_YEAR      = 5'd1;
  localparam logic [4:0] P_DASH1     = 5'd5;
  localparam logic [4:0] P_MON       = 5'd6;
  localparam logic [4:0] P_DASH2     = 5'd8;
  localparam logic [4:0] P_DAY       = 5'd9;
  localparam logic [4:0] P_DATE_END  = 5'd11;
  localparam logic [4:0] P_HOUR      = 5'd12;
  localparam logic [4:0] P_COL1      = 5'd14;
  localparam logic [4:0] P_MIN       = 5'd15;
  localparam logic [4:0] P_COL2      = 5'd17;
  localparam logic [4:0] P_SEC       = 5'd18;
  localparam logic [4:0] P_AFTER_SEC = 5'd20;
  localparam logic [4:0] P_FRAC1     = 5'd21;
  localparam logic [4:0] P_FRAC      = 5'd22;
  localparam logic [4:0] P_OHOUR     = 5'd23;
  localparam logic [4:0] P_OCOL      = 5'd25;
  localparam logic [4:0] P_OMIN      = 5'd26;
  localparam logic [4:0] P_DONE      = 5'd28;

  localparam int MIN_PER_DAY  = 60 * 24;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_WAIT  = 20;
  localparam int WORDS_PER_RUN = 500;

  typedef logic [7:0] text_t[$];

  class verdict_tracker;
    logic [4:0]  phase;
    logic [1:0]  fmt;
    logic        syn_bad;
    logic [13:0] yr;
    logic [6:0]  mon, dom, hr, mins, secs, off_hr, off_mins;
    logic        off_neg;
    logic [3:0]  expected_codes[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase = P_START;
      fmt = rdtv_pkg::FMT_DATE_TIME;
      syn_bad = 1'b0;
      yr = '0;
      mon = '0;
      dom = '0;
      hr = '0;
      mins = '0;
      secs = '0;
      off_neg = 1'b0;
      off_hr = '0;
      off_mins = '0;
    endfunction

    function void parse_char(logic [7:0] c);
      logic       dig;
      logic [3:0] d;
      logic       zulu;
      logic       sgn;
      dig = (c >= "0") && (c <= "9");
      d = dig ? c[3:0] : 4'd0;
      zulu = (c == "Z") || (c == "z");
      sgn = (c == "+") || (c == "-");
      case (phase)
        P_YEAR, P_YEAR + 5'd1, P_YEAR + 5'd2, P_YEAR + 5'd3, P_MON, P_MON + 5'd1,
        P_DAY, P_DAY + 5'd1, P_HOUR, P_HOUR + 5'd1, P_MIN, P_MIN + 5'd1,
        P_SEC, P_SEC + 5'd1, P_OHOUR, P_OHOUR + 5'd1, P_OMIN, P_OMIN + 5'd1: begin
          if (!dig) begin
            syn_bad = 1'b1;
          end else begin
            if (phase < P_DASH1) yr = 14'(yr * 10 + d);
            else if (phase < P_DASH2) mon = 7'(mon * 10 + d);
            else if (phase < P_DATE_END) dom = 7'(dom * 10 + d);
            else if (phase < P_COL1) hr = 7'(hr * 10 + d);
            else if (phase < P_COL2) mins = 7'(mins * 10 + d);
            else if (phase < P_AFTER_SEC) secs = 7'(secs * 10 + d);
            else if (phase < P_OCOL) off_hr = 7'(off_hr * 10 + d);
            else off_mins = 7'(off_mins * 10 + d);
            phase = phase + 5'd1;
          end
        end
        P_DASH1, P_DASH2: begin
          if (c == "-") phase = phase + 5'd1;
          else syn_bad = 1'b1;
        end
        P_COL1, P_COL2, P_OCOL: begin
          if (c == ":") phase = phase + 5'd1;
          else syn_bad = 1'b1;
        end
        P_DATE_END: begin
          if (fmt == rdtv_pkg::FMT_DATE_TIME && (c == "T" || c == "t")) phase = P_HOUR;
          else syn_bad = 1'b1;
        end
        P_AFTER_SEC, P_FRAC: begin
          if (phase == P_AFTER_SEC && c == ".") phase = P_FRAC1;
          else if (phase == P_FRAC && dig) phase = P_FRAC;
          else if (zulu) phase = P_DONE;
          else if (sgn) begin
            off_neg = (c == "-");
            phase = P_OHOUR;
          end else syn_bad = 1'b1;
        end
        P_FRAC1: begin
          if (dig) phase = P_FRAC;
          else syn_bad = 1'b1;
        end
        default: syn_bad = 1'b1;
      endcase
    endfunction

    function logic [3:0] date_error();
      int   y;
      int   m;
      int   dmax;
      logic leap;
      y = int'(yr);
      m = int'(mon);
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      if (m < 1 || m > 12) return rdtv_pkg::ERR_MONTH;
      if (m == 2) dmax = leap ? 29 : 28;
      else if (m <= 7) dmax = (m % 2 == 0) ? 30 : 31;
      else dmax = (m % 2 == 0) ? 31 : 30;
      if (dom < 1 || int'(dom) > dmax) return rdtv_pkg::ERR_DAY;
      return rdtv_pkg::ERR_OK;
    endfunction

    function logic [3:0] time_error();
      int zone;
      int utc;
      int smax;
      if (hr > 23) return rdtv_pkg::ERR_HOUR;
      if (mins > 59) return rdtv_pkg::ERR_MINUTE;
      if (off_hr > 23) return rdtv_pkg::ERR_OFF_HOUR;
      if (off_mins > 59) return rdtv_pkg::ERR_OFF_MIN;
      zone = int'(off_hr) * 60 + int'(off_mins);
      if (off_neg) zone = -zone;
      utc = int'(hr) * 60 + int'(mins) - zone;
      if (utc < 0) utc += MIN_PER_DAY;
      if (utc >= MIN_PER_DAY) utc -= MIN_PER_DAY;
      // leap second only at 23:59 utc
      smax = (utc == MIN_PER_DAY - 1) ? 60 : 59;
      if (int'(secs) > smax) return rdtv_pkg::ERR_SECOND;
      return rdtv_pkg::ERR_OK;
    endfunction

    function void note_char(logic [1:0] m, logic [7:0] c, logic last);
      logic [3:0] code;
      if (phase == P_START) begin
        fmt = m;
        phase = (fmt == rdtv_pkg::FMT_TIME) ? P_HOUR : P_YEAR;
        if (fmt == rdtv_pkg::FMT_BAD) syn_bad = 1'b1;
      end
      if (!syn_bad) parse_char(c);
      if (last) begin
        if (!syn_bad && phase != ((fmt == rdtv_pkg::FMT_DATE) ? P_DATE_END : P_DONE))
          syn_bad = 1'b1;
        code = syn_bad ? rdtv_pkg::ERR_SYNTAX : rdtv_pkg::ERR_OK;
        if (code == rdtv_pkg::ERR_OK && fmt != rdtv_pkg::FMT_TIME) code = date_error();
        if (code == rdtv_pkg::ERR_OK && fmt != rdtv_pkg::FMT_DATE) code = time_error();
        expected_codes.push_back(code);
        clear();
      end
    endfunction

    function void check_verdict(logic ok, logic [3:0] code);
      logic [3:0] want;
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, actual valid_res %0b error_code %0d",
                 $time, ok, code);
        mismatches++;
        return;
      end
      want = expected_codes.pop_front();
      if (ok !== (want == rdtv_pkg::ERR_OK)) begin
        $display("%0t: valid_res expected %0b actual %0b", $time,
                 want == rdtv_pkg::ERR_OK, ok);
        mismatches++;
      end
      if (code !== want) begin
        $display("%0t: error_code expected %0d actual %0d", $time, want, code);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] mode = rdtv_pkg::FMT_DATE_TIME;
  logic [7:0] char_byte = 8'h00;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       valid_res;
  logic [3:0] error_code;

  verdict_tracker verdicts = new();
  int quiet_cycles = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int stall_run = 0;

  rfc3339_date_time_validator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .char_byte (char_byte),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .valid_res (valid_res),
    .error_code(error_code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run <= $urandom_range(1, 12);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) verdicts.note_char(mode, char_byte, last_char);
      if (out_valid && !out_stall) verdicts.check_verdict(valid_res, error_code);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("rfc3339_date_time_validator_tb: FAIL");
    $finish;
  end

  task automatic send_char(input logic [1:0] m, input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= m;
    char_byte <= c;
    last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mode only matters on the first byte, so the rest carry noise there
  task automatic send_text(input logic [1:0] m, input text_t txt);
    for (int i = 0; i < txt.size(); i++)
      send_char((i == 0) ? m : 2'($urandom_range(0, 3)), txt[i], i == txt.size() - 1);
  endtask

  task automatic send_string(input logic [1:0] m, input string s);
    text_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_text(m, txt);
  endtask

  task automatic wait_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts.expected_codes.size() != 0);
  endtask

  function automatic void push_num(ref text_t t, input int v, input int n);
    int scale;
    scale = 1;
    repeat (n - 1) scale *= 10;
    repeat (n) begin
      t.push_back(8'(8'h30 + (v / scale) % 10));
      scale /= 10;
    end
  endfunction

  function automatic int pick_field(int lo, int hi);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi);
  endfunction

  function automatic void make_stamp(ref text_t t, output logic [1:0] m);
    int   yv, oh, om, zone, local_min, hh, mm, ss, kind, n;
    logic neg;
    t.delete();
    m = ($urandom_range(0, 39) == 0) ? rdtv_pkg::FMT_BAD : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) t.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (m != rdtv_pkg::FMT_TIME) begin
      case ($urandom_range(0, 9))
        0: yv = 0;
        1: yv = 9999;
        2: yv = 1900;
        3: yv = 400 * $urandom_range(0, 24);
        default: yv = $urandom_range(0, 9999);
      endcase
      push_num(t, yv, 4);
      t.push_back("-");
      push_num(t, pick_field(1, 12), 2);
      t.push_back("-");
      push_num(t, ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : pick_field(1, 31), 2);
      if (m != rdtv_pkg::FMT_DATE) t.push_back($urandom_range(0, 1) ? "T" : "t");
    end
    if (m != rdtv_pkg::FMT_DATE) begin
      neg = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 3);
      oh = 0;
      om = 0;
      if (kind >= 2) begin
        oh = pick_field(0, 23);
        om = pick_field(0, 59);
      end
      zone = oh * 60 + om;
      if (neg) zone = -zone;
      hh = pick_field(0, 23);
      mm = pick_field(0, 59);
      ss = pick_field(0, 59);
      if ($urandom_range(0, 3) == 0) begin
        ss = 60;
        if ($urandom_range(0, 1)) begin
          local_min = ((MIN_PER_DAY - 1 + zone) % MIN_PER_DAY + MIN_PER_DAY) % MIN_PER_DAY;
          hh = local_min / 60;
          mm = local_min % 60;
        end
      end
      push_num(t, hh, 2);
      t.push_back(":");
      push_num(t, mm, 2);
      t.push_back(":");
      push_num(t, ss, 2);
      if ($urandom_range(0, 2) == 0) begin
        t.push_back(".");
        push_num(t, $urandom_range(0, 999), $urandom_range(1, 3));
      end
      if (kind == 0) t.push_back("Z");
      else if (kind == 1) t.push_back("z");
      else begin
        t.push_back(neg ? "-" : "+");
        push_num(t, oh, 2);
        t.push_back(":");
        push_num(t, om, 2);
      end
    end
    // damaged strings: cut short, a byte swapped, a byte slipped in, trailing junk
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(0, t.size() - 1);
      case ($urandom_range(0, 3))
        0: t = t[0:n];
        1: t[n] = 8'($urandom_range(0, 255));
        2: t.insert(n, 8'($urandom_range(0, 255)));
        default: repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  initial begin
    text_t      txt;
    logic [1:0] m;
    int         sent;
    int         gaps[4];
    int         stalls[4];
    gaps = '{0, 3, 12, 1};
    stalls = '{0, 30, 70, 10};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    gap_max = 2;
    stall_pct = 20;
    send_string(rdtv_pkg::FMT_DATE_TIME, "2024-02-29T23:59:60Z");
    send_string(rdtv_pkg::FMT_DATE_TIME, "1900-02-29T00:00:00Z");
    send_string(rdtv_pkg::FMT_DATE_TIME, "2000-02-29t12:30:45.123456z");
    send_string(rdtv_pkg::FMT_DATE, "9999-12-31");
    send_string(rdtv_pkg::FMT_DATE, "0000-13-01");
    send_string(rdtv_pkg::FMT_DATE, "0000-00-10");
    send_string(rdtv_pkg::FMT_DATE, "2023-04-31");
    send_string(rdtv_pkg::FMT_DATE, "2023-01-00");
    send_string(rdtv_pkg::FMT_TIME, "24:00:00Z");
    send_string(rdtv_pkg::FMT_TIME, "23:60:00Z");
    send_string(rdtv_pkg::FMT_TIME, "00:00:00+24:00");
    send_string(rdtv_pkg::FMT_TIME, "00:00:00-00:60");
    send_string(rdtv_pkg::FMT_TIME, "99:99:99+99:99");
    send_string(rdtv_pkg::FMT_TIME, "15:59:60-08:00");
    send_string(rdtv_pkg::FMT_TIME, "23:59:60+00:01");
    send_string(rdtv_pkg::FMT_TIME, "00:29:60+00:30");
    send_string(rdtv_pkg::FMT_TIME, "23:59:60-23:59");
    send_string(rdtv_pkg::FMT_TIME, "12:00:61Z");
    send_string(rdtv_pkg::FMT_DATE_TIME, "2021-06-15 10:00:00Z");
    send_string(rdtv_pkg::FMT_DATE_TIME, "2021-06-15T10:00:00");
    send_string(rdtv_pkg::FMT_BAD, "2021-06-15");
    send_string(rdtv_pkg::FMT_DATE, "2021-06-1");
    send_string(rdtv_pkg::FMT_DATE, "2021-06-15T");
    send_string(rdtv_pkg::FMT_TIME, "10:00:00.");
    send_string(rdtv_pkg::FMT_TIME, "10:00:00.5Zx");
    send_string(rdtv_pkg::FMT_DATE, "2021-0a-15Z15");
    send_string(rdtv_pkg::FMT_DATE_TIME, "X");
    send_text(rdtv_pkg::FMT_DATE, {8'h00, 8'hFF});
    wait_verdicts();

    for (int run = 0; run < 4; run++) begin
      gap_max = gaps[run];
      stall_pct = stalls[run];
      sent = 0;
      while (sent < WORDS_PER_RUN) begin
        make_stamp(txt, m);
        send_text(m, txt);
        sent += txt.size();
      end
      wait_verdicts();
    end

    repeat (SETTLE_WAIT) @(posedge clk);
    if (verdicts.mismatches == 0 && verdicts.expected_codes.size() == 0) begin
      $display("rfc3339_date_time_validator_tb: PASS");
    end else begin
      $display("rfc3339_date_time_validator_tb: FAIL");
    end
    $finish;
  end

endmodule
